FILE: rtl/core/mcmp_pkg.sv
`default_nettype none
package mcmp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned KeyW   = 7;
  localparam int unsigned KindW  = 2;
  localparam int unsigned StateW = 3;

  // running status codes
  localparam logic [StateW-1:0] ST_NONE     = 3'd0;
  localparam logic [StateW-1:0] ST_NOTE_ON  = 3'd1;
  localparam logic [StateW-1:0] ST_NOTE_OFF = 3'd2;
  localparam logic [StateW-1:0] ST_CC       = 3'd3;
  localparam logic [StateW-1:0] ST_BEND     = 3'd4;

  // event kinds
  localparam logic [KindW-1:0] EV_NOTE_ON  = 2'd0;
  localparam logic [KindW-1:0] EV_NOTE_OFF = 2'd1;
  localparam logic [KindW-1:0] EV_CC       = 2'd2;
  localparam logic [KindW-1:0] EV_BEND     = 2'd3;

  // status nibbles
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CC       = 4'hB;
  localparam logic [3:0] NIB_BEND     = 4'hE;
  localparam logic [3:0] NIB_SYSTEM   = 4'hF;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key;
    logic [KeyW-1:0]  value;
  } event_t;

endpackage
`default_nettype wire

FILE: rtl/core/mcmp_parser.sv
`default_nettype none
module mcmp_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [mcmp_pkg::ChanW-1:0] cfg_chan_i,
  input  wire logic                       step_i,
  input  wire logic [mcmp_pkg::ByteW-1:0] byte_i,
  output logic                            evt_valid_o,
  output mcmp_pkg::event_t                evt_o
);
  import mcmp_pkg::*;

  logic [ChanW-1:0]  chan_q;
  logic [StateW-1:0] rs_q, rs_d;
  logic              note_pend_q, note_pend_d;
  logic              cc_pend_q, cc_pend_d;
  logic              bend_pend_q, bend_pend_d;
  logic [KeyW-1:0]   held_note_q, held_note_d;
  logic [KeyW-1:0]   held_cc_q, held_cc_d;
  logic [KeyW-1:0]   playing_q, playing_d;
  logic [KeyW-1:0]   data7;

  assign data7 = byte_i[KeyW-1:0];

  always_comb begin
    rs_d        = rs_q;
    note_pend_d = note_pend_q;
    cc_pend_d   = cc_pend_q;
    bend_pend_d = bend_pend_q;
    held_note_d = held_note_q;
    held_cc_d   = held_cc_q;
    playing_d   = playing_q;
    evt_valid_o = 1'b0;
    evt_o       = '{kind: EV_NOTE_ON, key: '0, value: '0};

    if (byte_i[7:4] == NIB_SYSTEM) begin
      // system bytes leave everything alone
    end else if (byte_i[7]) begin
      note_pend_d = 1'b0;
      cc_pend_d   = 1'b0;
      bend_pend_d = 1'b0;
      if (byte_i[3:0] != chan_q) begin
        rs_d = ST_NONE;
      end else begin
        case (byte_i[7:4])
          NIB_NOTE_ON:  rs_d = ST_NOTE_ON;
          NIB_NOTE_OFF: rs_d = ST_NOTE_OFF;
          NIB_CC:       rs_d = ST_CC;
          NIB_BEND:     rs_d = ST_BEND;
          default:      rs_d = ST_NONE;
        endcase
      end
    end else begin
      case (rs_q)
        ST_NOTE_ON, ST_NOTE_OFF: begin
          if (!note_pend_q) begin
            held_note_d = data7;
            note_pend_d = 1'b1;
          end else begin
            note_pend_d = 1'b0;
            if (rs_q == ST_NOTE_ON && data7 != '0) begin
              playing_d   = held_note_q;
              evt_valid_o = 1'b1;
              evt_o       = '{kind: EV_NOTE_ON, key: held_note_q, value: data7};
            end else if (held_note_q == playing_q) begin
              evt_valid_o = 1'b1;
              evt_o       = '{kind: EV_NOTE_OFF, key: held_note_q, value: '0};
            end
          end
        end
        ST_CC: begin
          if (!cc_pend_q) begin
            held_cc_d = data7;
            cc_pend_d = 1'b1;
          end else begin
            cc_pend_d   = 1'b0;
            evt_valid_o = 1'b1;
            evt_o       = '{kind: EV_CC, key: held_cc_q, value: data7};
          end
        end
        ST_BEND: begin
          // lsb is dropped, only the msb is reported
          if (!bend_pend_q) begin
            bend_pend_d = 1'b1;
          end else begin
            bend_pend_d = 1'b0;
            evt_valid_o = 1'b1;
            evt_o       = '{kind: EV_BEND, key: '0, value: data7};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= '0;
      rs_q        <= ST_NONE;
      note_pend_q <= 1'b0;
      cc_pend_q   <= 1'b0;
      bend_pend_q <= 1'b0;
      held_note_q <= '0;
      held_cc_q   <= '0;
      playing_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= cfg_chan_i;
      end
      if (step_i) begin
        rs_q        <= rs_d;
        note_pend_q <= note_pend_d;
        cc_pend_q   <= cc_pend_d;
        bend_pend_q <= bend_pend_d;
        held_note_q <= held_note_d;
        held_cc_q   <= held_cc_d;
        playing_q   <= playing_d;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/midi_channel_message_parser_unit.sv
`default_nettype none
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata[7:0] data_byte
// m_axis    out  m_axis_tvalid/tready      tdata[13:0] key,value; tuser[1:0] kind
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_data_i[3:0] listen_channel
//
// one byte per cycle sustained while the output is not stalled; a byte waits in
// the input register and its event, if any, is loaded into the output register
// when the byte steps the parser.
// reset clears running status, pair counters, held notes and the channel.
// a stalled output holds its beat and the input register stalls behind it.
module midi_channel_message_parser_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [6:0] key, [13:7] value, pad
  output logic [1:0]                      m_axis_tuser,  // [1:0] event_kind
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mcmp_pkg::ChanW-1:0] cfg_data_i
);
  import mcmp_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  event_t           out_evt_q;
  logic             out_free;
  logic             step;
  logic             evt_valid;
  event_t           evt;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;

  mcmp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_chan_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= step && evt_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (step && evt_valid && out_free) begin
      out_evt_q <= evt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_evt_q.value, out_evt_q.key};
  assign m_axis_tuser  = out_evt_q.kind;

endmodule
`default_nettype wire

FILE: sim/tb_midi_channel_message_parser_unit.sv
`timescale 1ns / 100ps

module tb_midi_channel_message_parser_unit;

  import mcmp_pkg::*;

  // channel voice nibbles the block does not decode, they only clear the status
  localparam logic [3:0] NIB_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] NIB_PROGRAM       = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESSURE = 4'hD;
  localparam logic [7:0] SYS_CLOCK_TICK    = 8'hF8;

  localparam int IdleLimit   = 2000;
  localparam int PhaseBytes  = 180;
  localparam int SettleTicks = 4;

  class channel_voice_model;
    logic [ChanW-1:0]  chan;
    logic [StateW-1:0] status;
    bit                note_half;
    logic [KeyW-1:0]   held_note;
    bit                cc_half;
    logic [KeyW-1:0]   held_ctl;
    bit                bend_half;
    logic [KeyW-1:0]   playing;
    event_t            pending_events[$];
    int                mismatches;
    int                checked;
    int                kind_seen[4];

    function new();
      chan      = '0;
      status    = ST_NONE;
      note_half = 0;
      held_note = '0;
      cc_half   = 0;
      held_ctl  = '0;
      bend_half = 0;
      playing   = '0;
      mismatches = 0;
      checked    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_channel(logic [ChanW-1:0] ch);
      chan = ch;
    endfunction

    function void push_event(logic [KindW-1:0] kind, logic [KeyW-1:0] key,
                             logic [KeyW-1:0] value);
      event_t ev;
      ev.kind  = kind;
      ev.key   = key;
      ev.value = value;
      pending_events.push_back(ev);
    endfunction

    function void take_byte(logic [7:0] b);
      if (b[7:4] == NIB_SYSTEM) return;
      if (b[7]) begin
        // any channel status byte restarts all three pairings
        note_half = 0;
        cc_half   = 0;
        bend_half = 0;
        if (b[3:0] != chan) begin
          status = ST_NONE;
        end else begin
          case (b[7:4])
            NIB_NOTE_ON:  status = ST_NOTE_ON;
            NIB_NOTE_OFF: status = ST_NOTE_OFF;
            NIB_CC:       status = ST_CC;
            NIB_BEND:     status = ST_BEND;
            default:      status = ST_NONE;
          endcase
        end
        return;
      end
      case (status)
        ST_NOTE_ON, ST_NOTE_OFF: begin
          if (!note_half) begin
            held_note = b[6:0];
            note_half = 1;
          end else begin
            note_half = 0;
            if (status == ST_NOTE_ON && b[6:0] != '0) begin
              playing = held_note;
              push_event(EV_NOTE_ON, held_note, b[6:0]);
            end else if (held_note == playing) begin
              push_event(EV_NOTE_OFF, held_note, '0);
            end
          end
        end
        ST_CC: begin
          if (!cc_half) begin
            held_ctl = b[6:0];
            cc_half  = 1;
          end else begin
            cc_half = 0;
            push_event(EV_CC, held_ctl, b[6:0]);
          end
        end
        ST_BEND: begin
          // lsb is dropped, only the msb is reported
          if (!bend_half) begin
            bend_half = 1;
          end else begin
            bend_half = 0;
            push_event(EV_BEND, '0, b[6:0]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_event(event_t got);
      event_t want;
      if (pending_events.size() == 0) begin
        $error("event beat with nothing expected: kind %0d key %0d value %0d",
               got.kind, got.key, got.value);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      checked++;
      kind_seen[want.kind]++;
      if (got.kind != want.kind) begin
        $error("event_kind expected %0d got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.key != want.key) begin
        $error("event_key expected %0d got %0d", want.key, got.key);
        mismatches++;
      end
      if (got.value != want.value) begin
        $error("event_value expected %0d got %0d", want.value, got.value);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [ChanW-1:0]  cfg_data_i;

  channel_voice_model book = new();

  int          burst_left = 0;
  int          bytes_sent = 0;
  int          useful_bytes = 0;
  int          settings_used = 0;
  int          idle_cycles = 0;
  int          stall_mode = 0;
  int          stall_span = 0;
  int unsigned tick = 0;
  logic [ChanW-1:0] listen = '0;

  midi_channel_message_parser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: switches between always ready, coin toss, a fixed rhythm and mostly stalled
  always @(posedge clk_i) begin
    tick <= tick + 1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(16, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (tick % 5) != 0;
      default: m_axis_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  // outputs are stable mid-cycle, so beats are taken at the falling edge
  always @(negedge clk_i) begin
    event_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind  = m_axis_tuser;
      got.key   = m_axis_tdata[6:0];
      got.value = m_axis_tdata[13:7];
      book.check_event(got);
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles without a beat", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(negedge clk_i); while (!s_axis_tready);
    book.take_byte(b);
    bytes_sent++;
    if (b[7:4] != NIB_SYSTEM) useful_bytes++;
    @(posedge clk_i);
  endtask

  // lets the pipeline empty so a register write cannot overtake a byte
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (book.pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_channel(input logic [ChanW-1:0] ch);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ch;
    do @(negedge clk_i); while (!cfg_ready_o);
    book.set_channel(ch);
    listen = ch;
    settings_used++;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_message();
    int         pick;
    logic [3:0] nib;
    logic [3:0] ch;
    logic [6:0] d0;
    logic [6:0] d1;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 10) begin
      send_byte({NIB_SYSTEM, 4'($urandom_range(0, 15))});
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: nib = NIB_NOTE_ON;
      3, 4:    nib = NIB_NOTE_OFF;
      5, 6:    nib = NIB_CC;
      7:       nib = NIB_BEND;
      8:       nib = NIB_POLY_PRESSURE;
      default: nib = $urandom_range(0, 1) ? NIB_PROGRAM : NIB_CHAN_PRESSURE;
    endcase
    ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : listen;
    // a quarter of messages lean on running status
    if ($urandom_range(0, 3) != 0) send_byte({nib, ch});
    if ((nib == NIB_NOTE_ON || nib == NIB_NOTE_OFF) && $urandom_range(0, 2) != 0) begin
      d0 = 7'(60 + $urandom_range(0, 3));
    end else begin
      d0 = 7'($urandom_range(0, 127));
    end
    d1 = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(0, 127));
    send_byte({1'b0, d0});
    if ($urandom_range(0, 19) == 0) send_byte(SYS_CLOCK_TICK);
    if ($urandom_range(0, 15) != 0) send_byte({1'b0, d1});
  endtask

  initial begin
    logic [7:0]       directed[$];
    logic [ChanW-1:0] phase_chan[6];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_channel(4'd0);
    directed = '{
      8'h90, 8'h00, 8'h7F,          // note on, extreme key and velocity
      8'h7F, 8'h01,                 // running status, key 127 now playing
      8'h7F, 8'h00,                 // zero velocity on the playing note
      8'h05, 8'h00,                 // zero velocity on a silent note, no event
      8'h80, 8'h7F, 8'h40,          // note off on the playing note
      8'hB0, 8'h07, 8'hF8, 8'h64,   // control change with a system byte inside
      8'hE0, 8'h12, 8'h7F,          // bend, lsb dropped
      8'h90, 8'h3C, 8'hA0, 8'h10,   // note on, then an undecoded status mid-pair
      8'h91, 8'h10                  // another channel clears the status
    };
    foreach (directed[i]) send_byte(directed[i]);
    drain();

    phase_chan = '{4'd0, 4'd15, 4'($urandom_range(1, 14)), 4'd0,
                   4'($urandom_range(0, 15)), 4'd15};
    foreach (phase_chan[p]) begin
      if (p != 0) write_channel(phase_chan[p]);
      useful_bytes = 0;
      while (useful_bytes < PhaseBytes) send_message();
      drain();
    end

    $display("covered %0d bytes over %0d channel settings, extremes 0 and 15 included",
             bytes_sent, settings_used);
    $display("checked %0d events: %0d note on, %0d note off, %0d control, %0d bend",
             book.checked, book.kind_seen[EV_NOTE_ON], book.kind_seen[EV_NOTE_OFF],
             book.kind_seen[EV_CC], book.kind_seen[EV_BEND]);
    if (book.mismatches == 0 && book.pending_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
